// ----- rtl/pmi_pkg.sv -----
// ----------------------------------------------------------------------------
// pmi_pkg
// Types, constants and helpers shared by the population map iterator.
// ----------------------------------------------------------------------------
`default_nettype none
package pmi_pkg;

    localparam logic signed [31:0] Q_ONE   = 32'sd16777216;
    localparam logic signed [31:0] Q_MAX   = 32'sh7FFFFFFF;
    localparam logic signed [31:0] Q_MIN   = 32'sh80000000;
    localparam logic        [29:0] Q_LN2   = 30'd11629080;
    localparam logic signed [31:0] Z_HIGH  = 32'sd83886080;
    localparam logic signed [31:0] Z_LOW   = -32'sd301989888;
    localparam logic signed [32:0] Z_OFS   = 33'sd302356080;
    localparam logic        [5:0]  K_OFS   = 6'd26;
    localparam logic        [3:0]  EXP_TERMS = 4'd12;

    localparam logic [1:0] MODEL_EXP = 2'd0;
    localparam logic [1:0] MODEL_LOG = 2'd1;
    localparam logic [1:0] MODEL_RICKER = 2'd2;
    localparam logic [1:0] MODEL_NB = 2'd3;

    localparam logic [2:0] REG_MODEL = 3'd0;
    localparam logic [2:0] REG_GROWTH = 3'd1;
    localparam logic [2:0] REG_SEARCH = 3'd2;
    localparam logic [2:0] REG_HOST = 3'd3;
    localparam logic [2:0] REG_YIELD = 3'd4;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic [1:0]         model_select;
        logic signed [31:0] growth_rate;
        logic signed [31:0] search_efficiency;
        logic signed [31:0] host_growth;
        logic signed [31:0] parasite_yield;
    } t_cfg;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] v;
    } t_sat;

    function automatic t_sat f_qmul(input logic signed [65:0] p);
        logic signed [65:0] s;
        t_sat r;
        s = (p + 66'sd8388608) >>> 24;
        if (s > 66'sd2147483647) begin
            r = '{1'b1, Q_MAX};
        end else if (s < -66'sd2147483648) begin
            r = '{1'b1, Q_MIN};
        end else begin
            r = '{1'b0, s[31:0]};
        end
        return r;
    endfunction

    function automatic t_sat f_qsub(input logic signed [31:0] a,
                                    input logic signed [31:0] b);
        logic signed [32:0] d;
        t_sat r;
        d = 33'(a) - 33'(b);
        if (d > 33'sd2147483647) begin
            r = '{1'b1, Q_MAX};
        end else if (d < -33'sd2147483648) begin
            r = '{1'b1, Q_MIN};
        end else begin
            r = '{1'b0, d[31:0]};
        end
        return r;
    endfunction

    // floor((2^32 - 1) / i)
    function automatic logic [31:0] f_recip(input logic [3:0] i);
        logic [31:0] r;
        unique case (i)
            4'd1:    r = 32'd4294967295;
            4'd2:    r = 32'd2147483647;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741823;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870911;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            4'd11:   r = 32'd390451572;
            4'd12:   r = 32'd357913941;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pmi_in_if.sv -----
// ----------------------------------------------------------------------------
// pmi_in_if
// Input item channel: seed or step command.
// ----------------------------------------------------------------------------
`default_nettype none
interface pmi_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [31:0] seed_host;
    logic signed [31:0] seed_parasite;
    modport source(output valid, operation, seed_host, seed_parasite, input ready);
    modport sink(input valid, operation, seed_host, seed_parasite, output ready);
endinterface
`default_nettype wire

// ----- rtl/pmi_out_if.sv -----
// ----------------------------------------------------------------------------
// pmi_out_if
// Result item channel: population pair and saturation flag.
// ----------------------------------------------------------------------------
`default_nettype none
interface pmi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] host_value;
    logic signed [31:0] parasite_value;
    logic               saturated;
    modport source(output valid, host_value, parasite_value, saturated, input ready);
    modport sink(input valid, host_value, parasite_value, saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/pmi_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pmi_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface pmi_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/pmi_mul.sv -----
// ----------------------------------------------------------------------------
// pmi_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none
module pmi_mul (
    input  wire logic               i_clk,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [32:0] i_b,
    output logic signed [65:0]      o_prod
);
    logic signed [65:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

// ----- rtl/pmi_seq.sv -----
// ----------------------------------------------------------------------------
// pmi_seq
// Sequencer and datapath: runs each model's multiplies and the Taylor series
// through the shared multiplier and does the exponent range reduction.
// ----------------------------------------------------------------------------
`default_nettype none
module pmi_seq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pmi_pkg::t_cfg        i_cfg,
    pmi_in_if.sink                    i_in,
    pmi_out_if.source                 o_out,
    output logic signed [32:0]        o_mul_a,
    output logic signed [32:0]        o_mul_b,
    input  wire logic signed [65:0]   i_prod
);
    import pmi_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_A    = 4'd1;
    localparam logic [3:0] S_B    = 4'd2;
    localparam logic [3:0] S_C    = 4'd3;
    localparam logic [3:0] S_EXP  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_TA   = 4'd6;
    localparam logic [3:0] S_TB   = 4'd7;
    localparam logic [3:0] S_TC   = 4'd8;
    localparam logic [3:0] S_SC   = 4'd9;
    localparam logic [3:0] S_E1   = 4'd10;
    localparam logic [3:0] S_E2   = 4'd11;
    localparam logic [3:0] S_E3   = 4'd12;
    localparam logic [3:0] S_E4   = 4'd13;
    localparam logic [3:0] S_E5   = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    logic [3:0]         r_state;
    logic signed [31:0] r_x, r_y, r_nx, r_ny, r_t, r_t2, r_e, r_z;
    logic [29:0]        r_rem;
    logic [5:0]         r_k;
    logic [2:0]         r_cnt;
    logic [31:0]        r_term, r_v;
    logic [33:0]        r_sum;
    logic [3:0]         r_i;
    logic               r_flag;

    t_sat        qp, sub1x, negz, sub1e;
    logic [29:0] lim, f30;
    logic [32:0] zofs;
    logic [31:0] v, q0, q;
    logic [35:0] qi, rr;
    logic [5:0]  sh;
    logic [35:0] scaled;
    logic [1:0]  model;

    assign model = i_cfg.model_select;
    assign qp    = f_qmul(i_prod);
    assign sub1x = f_qsub(Q_ONE, r_x);
    assign negz  = f_qsub(32'sd0, qp.v);
    assign sub1e = f_qsub(Q_ONE, r_e);
    assign lim   = Q_LN2 << r_cnt;
    assign f30   = {r_rem[23:0], 6'b0};
    assign zofs  = 33'(r_z) + Z_OFS;
    assign v     = i_prod[61:30];
    assign q0    = i_prod[63:32];
    assign qi    = 36'(q0) * 36'(r_i);
    assign rr    = 36'(r_v) - qi;
    assign q     = (rr >= 36'(r_i)) ? q0 + 32'd1 : q0;
    assign sh    = 6'd32 - r_k;

    always_comb begin
        if (r_k == 6'd33) begin
            scaled = 36'(r_sum) << 1;
        end else if (r_k == 6'd32) begin
            scaled = 36'(r_sum);
        end else begin
            scaled = (36'(r_sum) + (36'd1 << (sh - 6'd1))) >> sh;
        end
    end

    always_comb begin
        o_mul_a = '0;
        o_mul_b = '0;
        unique case (r_state)
            S_A: begin
                unique case (model)
                    MODEL_EXP, MODEL_LOG: begin
                        o_mul_a = 33'(i_cfg.growth_rate);
                        o_mul_b = 33'(r_x);
                    end
                    MODEL_RICKER: begin
                        o_mul_a = 33'(i_cfg.growth_rate);
                        o_mul_b = 33'(sub1x.v);
                    end
                    default: begin
                        o_mul_a = 33'(i_cfg.search_efficiency);
                        o_mul_b = 33'(r_y);
                    end
                endcase
            end
            S_B: begin
                o_mul_a = 33'(qp.v);
                o_mul_b = 33'(r_t);
            end
            S_E1: begin
                o_mul_a = (model == MODEL_NB) ? 33'(i_cfg.host_growth) : 33'(r_e);
                o_mul_b = 33'(r_x);
            end
            S_E2: begin
                o_mul_a = 33'(i_cfg.parasite_yield);
                o_mul_b = 33'(r_x);
            end
            S_E3: begin
                o_mul_a = 33'(r_t);
                o_mul_b = 33'(r_e);
            end
            S_E4: begin
                o_mul_a = 33'(r_t2);
                o_mul_b = 33'(sub1e.v);
            end
            S_TA: begin
                o_mul_a = {1'b0, r_term};
                o_mul_b = {3'b0, f30};
            end
            S_TB: begin
                o_mul_a = {1'b0, v};
                o_mul_b = {1'b0, f_recip(r_i)};
            end
            default: begin
                o_mul_a = '0;
                o_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_x     <= '0;
            r_y     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.operation == OP_SEED) begin
                            r_x <= i_in.seed_host;
                            r_y <= i_in.seed_parasite;
                        end else begin
                            r_flag  <= 1'b0;
                            r_nx    <= r_x;
                            r_ny    <= r_y;
                            r_state <= S_A;
                        end
                    end
                end
                S_A: begin
                    r_t <= sub1x.v;
                    if (model == MODEL_LOG || model == MODEL_RICKER) begin
                        r_flag <= r_flag | sub1x.ovf;
                    end
                    r_state <= S_B;
                end
                S_B: begin
                    unique case (model)
                        MODEL_EXP: begin
                            r_nx    <= qp.v;
                            r_flag  <= r_flag | qp.ovf;
                            r_state <= S_OUT;
                        end
                        MODEL_LOG: begin
                            r_flag  <= r_flag | qp.ovf;
                            r_state <= S_C;
                        end
                        MODEL_RICKER: begin
                            r_z     <= qp.v;
                            r_flag  <= r_flag | qp.ovf;
                            r_state <= S_EXP;
                        end
                        default: begin
                            r_z     <= negz.v;
                            r_flag  <= r_flag | qp.ovf | negz.ovf;
                            r_state <= S_EXP;
                        end
                    endcase
                end
                S_C: begin
                    r_nx    <= qp.v;
                    r_flag  <= r_flag | qp.ovf;
                    r_state <= S_OUT;
                end
                S_EXP: begin
                    r_term <= 32'd1 << 30;
                    r_sum  <= 34'd1 << 30;
                    r_i    <= 4'd1;
                    priority if (r_z >= Z_HIGH) begin
                        r_e     <= Q_MAX;
                        r_flag  <= 1'b1;
                        r_state <= S_E1;
                    end else if (r_z < Z_LOW) begin
                        r_e     <= '0;
                        r_state <= S_E1;
                    end else begin
                        r_rem   <= zofs[29:0];
                        r_k     <= '0;
                        r_cnt   <= 3'd5;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_rem >= lim) begin
                        r_rem        <= r_rem - lim;
                        r_k[r_cnt]   <= 1'b1;
                    end
                    r_cnt <= r_cnt - 3'd1;
                    if (r_cnt == 3'd0) begin
                        r_state <= S_TA;
                    end
                end
                S_TA: begin
                    r_state <= S_TB;
                end
                S_TB: begin
                    r_v     <= v;
                    r_state <= S_TC;
                end
                S_TC: begin
                    r_term <= q;
                    r_sum  <= r_sum + 34'(q);
                    r_i    <= r_i + 4'd1;
                    r_state <= (r_i == EXP_TERMS) ? S_SC : S_TA;
                end
                S_SC: begin
                    if (scaled > 36'h07FFFFFFF) begin
                        r_e    <= Q_MAX;
                        r_flag <= 1'b1;
                    end else begin
                        r_e <= scaled[31:0];
                    end
                    r_state <= S_E1;
                end
                S_E1: begin
                    r_state <= S_E2;
                end
                S_E2: begin
                    r_flag <= r_flag | qp.ovf;
                    if (model == MODEL_NB) begin
                        r_t     <= qp.v;
                        r_state <= S_E3;
                    end else begin
                        r_nx    <= qp.v;
                        r_state <= S_OUT;
                    end
                end
                S_E3: begin
                    r_t2    <= qp.v;
                    r_flag  <= r_flag | qp.ovf;
                    r_state <= S_E4;
                end
                S_E4: begin
                    r_nx    <= qp.v;
                    r_flag  <= r_flag | qp.ovf | sub1e.ovf;
                    r_state <= S_E5;
                end
                S_E5: begin
                    r_ny    <= qp.v;
                    r_flag  <= r_flag | qp.ovf;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_x     <= r_nx;
                        r_y     <= r_ny;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = (r_state == S_OUT);
    assign o_out.host_value     = r_x;
    assign o_out.parasite_value = r_y;
    assign o_out.saturated      = r_flag;
endmodule
`default_nettype wire

// ----- rtl/population_map_iterator.sv -----
// ----------------------------------------------------------------------------
// population_map_iterator
// Discrete population map iterator in signed Q8.24 fixed point.
//
// i_in carries items: a seed item loads the host and parasite levels and
// gives no result; a step item gives one result on o_out holding the pair
// before the step and the saturation flag of the update it computes.
// i_cfg writes the model select, rate and coefficient registers; it is
// always ready, and the user must write it only while the block is idle;
// the block itself does not enforce this. One item is in work at a time;
// i_in.ready is low from step accept until its result is taken, and a
// seed leaves it high. The shared multiplier carries the model and series
// products; for Ricker and host-parasite an in-range exponent adds a
// range reduction and a series of 12 terms, each through S_TA, S_TB and
// S_TC. The block is ready again the cycle after the result is taken.
// The result is held on o_out until o_out.ready; the levels advance then.
// Reset clears both levels to zero and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module population_map_iterator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pmi_in_if.sink    i_in,
    pmi_out_if.source o_out,
    pmi_cfg_if.sink   i_cfg
);
    import pmi_pkg::*;

    t_cfg               r_cfg;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.model_select      <= MODEL_LOG;
            r_cfg.growth_rate       <= Q_ONE;
            r_cfg.search_efficiency <= '0;
            r_cfg.host_growth       <= Q_ONE;
            r_cfg.parasite_yield    <= Q_ONE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MODEL:  r_cfg.model_select      <= i_cfg.data[1:0];
                REG_GROWTH: r_cfg.growth_rate       <= i_cfg.data;
                REG_SEARCH: r_cfg.search_efficiency <= i_cfg.data;
                REG_HOST:   r_cfg.host_growth       <= i_cfg.data;
                REG_YIELD:  r_cfg.parasite_yield    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    pmi_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    pmi_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_mul_a (mul_a),
        .o_mul_b (mul_b),
        .i_prod  (prod)
    );
endmodule
`default_nettype wire
